// File: rtl/core/sled_pkg.sv
// Package for the start/length/end byte deframer.
// Sequencer state type and configuration register indexes; no dependencies.
package sled_pkg;

    typedef logic [7:0] byte_t;

    // Configuration register indexes
    localparam logic CFG_START_BYTE = 1'b0;
    localparam logic CFG_END_BYTE   = 1'b1;

    // Smallest legal frame: start, length and end bytes, empty payload
    localparam byte_t MIN_FRAME_LEN = 8'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_LEN_RD,
        ST_LEN_EV,
        ST_END_RD,
        ST_END_EV,
        ST_EMIT_RD,
        ST_EMIT_EV
    } sled_state_t;

endpackage

// File: rtl/core/sled_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module sled_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/start_length_end_deframer_top.sv
// Start/length/end byte deframer, top level. Uses sled_pkg and sled_ram.
// A byte is taken only in idle; after its write each window RAM read (start,
// length, end byte, each byte discarded by a rescan, each payload byte) takes a
// read and an evaluate state on the single read port. After the closing byte's
// transfer SCAN, LEN, END and EMIT each run _RD then _EV, and EMIT_EV registers
// the first payload byte. Reset clears the sequencer, fill, head, out_valid and
// config registers; the window RAM is not, as only entries below fill are read.
module start_length_end_deframer_top
    import sled_pkg::*;
#(
    parameter int MAX_FRAME = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // received byte stream
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    // payload stream
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       frame_last,
    output logic [5:0] payload_length
);

    // PW: window pointer width, FW: fill count width (holds MAX_FRAME itself)
    localparam int PW = $clog2(MAX_FRAME);
    localparam int FW = $clog2(MAX_FRAME + 1);
    localparam int CW = (FW > 8 ? FW : 8) + 1;
    localparam logic [FW:0]   MAX_EXT = (FW + 1)'(MAX_FRAME);
    localparam logic [FW-1:0] MAX_FILL = FW'(MAX_FRAME);
    localparam logic [CW-1:0] MAX_CMP = CW'(MAX_FRAME);

    // Circular window: head points at the oldest byte held
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [FW-1:0] offs);
        logic [FW:0] sum;
        sum = {{(FW + 1 - PW){1'b0}}, base} + {1'b0, offs};
        if (sum >= MAX_EXT)
        begin
            sum = sum - MAX_EXT;
        end
        return sum[PW-1:0];
    endfunction

    sled_state_t   state_reg, state_next;
    logic [PW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    byte_t         len_reg, len_next;
    byte_t         k_reg, k_next;
    byte_t         start_byte_reg, end_byte_reg;

    logic          out_valid_reg, out_valid_next;
    byte_t         payload_byte_reg, payload_byte_next;
    logic          frame_last_reg, frame_last_next;
    logic [5:0]    payload_length_reg, payload_length_next;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [PW-1:0] ram_raddr;
    byte_t         ram_rdata;

    byte_t         count;
    logic          last_k;
    logic          out_free;
    logic [FW-1:0] fill_dec;
    logic [PW-1:0] head_inc;

    sled_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration registers; the user keeps the stream quiet around writes, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= '0;
            end_byte_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data;
                CFG_END_BYTE:   end_byte_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        len_reg            <= len_next;
        k_reg              <= k_next;
        payload_byte_reg   <= payload_byte_next;
        frame_last_reg     <= frame_last_next;
        payload_length_reg <= payload_length_next;
    end

    assign count    = len_reg - MIN_FRAME_LEN;
    assign last_k   = (k_reg + 8'd1) == count;
    assign out_free = !out_valid_reg || out_ready;
    assign fill_dec = fill_reg - FW'(1);
    assign head_inc = wrap_add(head_reg, FW'(1));

    assign in_ready  = (state_reg == ST_IDLE);
    assign ram_we    = in_valid && in_ready;
    // head + fill also lands on head when the window is full (oldest overwritten)
    assign ram_waddr = wrap_add(head_reg, fill_reg);

    always_comb
    begin
        state_next          = state_reg;
        head_next           = head_reg;
        fill_next           = fill_reg;
        len_next            = len_reg;
        k_next              = k_reg;
        payload_byte_next   = payload_byte_reg;
        frame_last_next     = frame_last_reg;
        payload_length_next = payload_length_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        ram_raddr           = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (fill_reg == MAX_FILL)
                    begin
                        head_next = head_inc;
                    end
                    else
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end

            // Front byte: keep if start byte, else drop and rescan
            ST_SCAN_EV:
            begin
                if (ram_rdata == start_byte_reg)
                begin
                    state_next = (fill_reg < FW'(2)) ? ST_IDLE : ST_LEN_RD;
                end
                else
                begin
                    head_next  = head_inc;
                    fill_next  = fill_dec;
                    state_next = (fill_dec == '0) ? ST_IDLE : ST_SCAN_RD;
                end
            end

            ST_LEN_RD:
            begin
                ram_raddr  = head_inc;
                state_next = ST_LEN_EV;
            end

            ST_LEN_EV:
            begin
                ram_raddr = head_inc;
                len_next  = ram_rdata;
                if (ram_rdata < MIN_FRAME_LEN || CW'(ram_rdata) > MAX_CMP)
                begin
                    head_next  = head_inc;
                    fill_next  = fill_dec;
                    state_next = (fill_dec == '0) ? ST_IDLE : ST_SCAN_RD;
                end
                else if (CW'(fill_reg) < CW'(ram_rdata))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_END_RD;
                end
            end

            ST_END_RD:
            begin
                ram_raddr  = wrap_add(head_reg, FW'(len_reg - 8'd1));
                state_next = ST_END_EV;
            end

            ST_END_EV:
            begin
                ram_raddr = wrap_add(head_reg, FW'(len_reg - 8'd1));
                if (ram_rdata != end_byte_reg)
                begin
                    head_next  = head_inc;
                    fill_next  = fill_dec;
                    state_next = (fill_dec == '0) ? ST_IDLE : ST_SCAN_RD;
                end
                else if (len_reg == MIN_FRAME_LEN)
                begin
                    // empty payload: frame leaves the window silently
                    head_next  = wrap_add(head_reg, FW'(len_reg));
                    fill_next  = fill_reg - FW'(len_reg);
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                ram_raddr  = wrap_add(head_reg, FW'(k_reg + 8'd2));
                state_next = ST_EMIT_EV;
            end

            // Hold the read address so rdata stays put while the output stalls
            ST_EMIT_EV:
            begin
                ram_raddr = wrap_add(head_reg, FW'(k_reg + 8'd2));
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    payload_byte_next   = ram_rdata;
                    frame_last_next     = last_k;
                    payload_length_next = count[5:0];
                    if (last_k)
                    begin
                        head_next  = wrap_add(head_reg, FW'(len_reg));
                        fill_next  = fill_reg - FW'(len_reg);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 8'd1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = payload_byte_reg;
    assign frame_last     = frame_last_reg;
    assign payload_length = payload_length_reg;

    // Window bookkeeping never runs past the RAM
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= MAX_FILL) && (32'(head_reg) < 32'(MAX_FRAME)))
        else $error("window fill or head out of range");

    // Payload is only walked for a frame that is wholly held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_EV) |-> (CW'(fill_reg) >= CW'(len_reg)))
        else $error("emitting a frame that is not complete");

    // A waiting result is never overwritten or lost
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(payload_byte_reg)))
        else $error("stalled result dropped");

endmodule
